// File: design/fded_pkg.sv
// Shared types and constants of the FAT directory entry decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package fded_pkg;

    // Defaults of the top-level parameters.
    localparam int NAME_BUFFER_BYTES_DEF   = 256;
    localparam int MAX_LONG_NAME_ORDER_DEF = 20;

    // Positions in the name buffer reach (31 - 1) * 13 + 12 = 402 at most.
    localparam int POS_W   = 9;
    localparam int ROW_W   = POS_W - 3;
    localparam int ORDER_W = 5;
    localparam int CHUNK_W = 5;
    localparam int LFN_CHARS = 13;

    localparam logic [7:0]  ATTR_LFN      = 8'h0F;
    localparam logic [7:0]  FIRST_DELETED = 8'hE5;
    localparam logic [7:0]  CHAR_SPACE    = 8'h20;
    localparam logic [7:0]  CHAR_DOT      = 8'h2E;
    localparam logic [15:0] UNIT_UNUSED   = 16'hFFFF;
    localparam int          LFN_START_BIT = 6;
    localparam int          ATTR_DIR_BIT  = 4;
    localparam logic [CHUNK_W-1:0] LAST_CHUNK = 5'd31;

    // Byte offsets of the thirteen UTF-16 units inside a long-name entry.
    localparam logic [4:0] LFN_UNIT_OFS [LFN_CHARS] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9,
        5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24,
        5'd28, 5'd30
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;       // capture the accepted entry
        logic src_long;  // name comes from the long-name buffer (sampled with cap)
        logic clr_buf;   // clear the whole long-name buffer
        logic rd_lfn;    // read the current buffer row
        logic wr_lfn;    // write the merged row, then read the next one
        logic rd_chunk;  // read the row of the current chunk
        logic ld_out;    // load the current chunk into the result register
        logic ld_end;    // load the end-of-listing result
    } fded_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic first_zero;
        logic deleted;
        logic lfn;
        logic lfn_start;
        logic order_ok;
        logic row_is_end;
        logic chunk_last;
        logic out_free;
    } fded_status_t;

endpackage

`default_nettype wire

// File: design/fat_directory_entry_decoder.sv
// FAT directory entry decoder top level; uses fded_pkg, fded_ctrl and fded_datapath.
// A plain entry is captured, then each chunk of its name takes a RAM read and then a
// result load; a load waits while the result register is stalled. A start, deleted or
// ignored entry is only taken; an end marker then loads the end result; a long-name entry
// takes a read, then one write per buffer row touched (it is only taken with an order out
// of range). Reset clears the row valid bits and both flags at once.
`default_nettype none

module fat_directory_entry_decoder #(
    parameter int NAME_BUFFER_BYTES   = fded_pkg::NAME_BUFFER_BYTES_DEF,
    parameter int MAX_LONG_NAME_ORDER = fded_pkg::MAX_LONG_NAME_ORDER_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Entry channel.
    input  wire logic        entry_valid,
    output      logic        entry_stall,
    input  wire logic        kind,
    input  wire logic [63:0] entry_word0,
    input  wire logic [63:0] entry_word1,
    input  wire logic [63:0] entry_word2,
    input  wire logic [63:0] entry_word3,
    // Result channel.
    output      logic        result_valid,
    input  wire logic        result_stall,
    output      logic [63:0] name_chars,
    output      logic [4:0]  chunk_index,
    output      logic        is_directory,
    output      logic        end_of_directory,
    output      logic        last
);

    import fded_pkg::*;

    fded_cmd_t    cmd;
    fded_status_t status;

    // The controller sequences each entry: it takes a transfer only when idle,
    // walks the buffer rows that a long-name fragment touches, and steps the
    // chunks of a name through the result register.
    fded_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (entry_valid),
        .status      (status),
        .entry_stall (entry_stall),
        .cmd         (cmd)
    );

    // The datapath decodes the entry, owns the name buffer and the result
    // register. The result register parts the two channels, so a finished
    // chunk may wait for its transfer while the controller goes on.
    fded_datapath #(
        .NAME_BUFFER_BYTES   (NAME_BUFFER_BYTES),
        .MAX_LONG_NAME_ORDER (MAX_LONG_NAME_ORDER)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .kind             (kind),
        .entry_word0      (entry_word0),
        .entry_word1      (entry_word1),
        .entry_word2      (entry_word2),
        .entry_word3      (entry_word3),
        .cmd              (cmd),
        .result_stall     (result_stall),
        .status           (status),
        .result_valid     (result_valid),
        .name_chars       (name_chars),
        .chunk_index      (chunk_index),
        .is_directory     (is_directory),
        .end_of_directory (end_of_directory),
        .last             (last)
    );

`ifndef SYNTHESIS
    // The end result is a single empty chunk that closes the run.
    a_end_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && end_of_directory
        |-> last && name_chars == 64'h0 && chunk_index == 5'd0 && !is_directory)
        else $error("end result is not a single empty last chunk");

    // A chunk that is not the last one carries eight characters and no terminator.
    a_full_middle_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last
        |-> name_chars[7:0] != 8'h00 && name_chars[15:8] != 8'h00
            && name_chars[23:16] != 8'h00 && name_chars[31:24] != 8'h00
            && name_chars[39:32] != 8'h00 && name_chars[47:40] != 8'h00
            && name_chars[55:48] != 8'h00 && name_chars[63:56] != 8'h00)
        else $error("non-last chunk holds a terminator");

    // The controller never loads a chunk and the end result in the same cycle, and never
    // reads a chunk or loads a result while buffer rows are being read or written.
    a_exclusive_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ld_out || cmd.ld_end || cmd.rd_chunk)
        |-> !cmd.wr_lfn && !cmd.rd_lfn && !(cmd.ld_out && cmd.ld_end))
        else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

// File: design/fded_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module fded_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/fded_ctrl.sv
// Controller state machine of the FAT directory entry decoder.
// Depends on fded_pkg for the command and status structs.
`default_nettype none

module fded_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   entry_valid,
    input  wire fded_pkg::fded_status_t status,
    output      logic                   entry_stall,
    output      fded_pkg::fded_cmd_t    cmd
);

    import fded_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LFN_RD  = 3'd1;
    localparam logic [2:0] S_LFN_WR  = 3'd2;
    localparam logic [2:0] S_EMIT_RD = 3'd3;
    localparam logic [2:0] S_EMIT_LD = 3'd4;
    localparam logic [2:0] S_END_LD  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       pending_reg, pending_next;
    logic       done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            done_reg    <= done_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        done_next    = done_reg;
        cmd          = '0;
        entry_stall  = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (entry_valid)
                begin
                    if (!status.kind)
                    begin
                        cmd.clr_buf  = 1'b1;
                        pending_next = 1'b0;
                        done_next    = 1'b0;
                    end
                    else if (!done_reg)
                    begin
                        if (status.first_zero)
                        begin
                            done_next  = 1'b1;
                            state_next = S_END_LD;
                        end
                        else if (status.deleted)
                        begin
                            pending_next = 1'b0;
                        end
                        else if (status.lfn)
                        begin
                            cmd.cap = 1'b1;
                            if (status.lfn_start)
                            begin
                                cmd.clr_buf  = 1'b1;
                                pending_next = 1'b1;
                            end
                            if (status.order_ok)
                            begin
                                state_next = S_LFN_RD;
                            end
                        end
                        else
                        begin
                            cmd.cap      = 1'b1;
                            cmd.src_long = pending_reg;
                            pending_next = 1'b0;
                            state_next   = S_EMIT_RD;
                        end
                    end
                end
            end
            S_LFN_RD:
            begin
                cmd.rd_lfn = 1'b1;
                state_next = S_LFN_WR;
            end
            S_LFN_WR:
            begin
                cmd.wr_lfn = 1'b1;
                if (status.row_is_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT_RD:
            begin
                cmd.rd_chunk = 1'b1;
                state_next   = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = status.chunk_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_END_LD:
            begin
                if (status.out_free)
                begin
                    cmd.ld_end = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/fded_datapath.sv
// Datapath of the FAT directory entry decoder: entry decode, name buffer,
// long-name merge, chunk formation and the result register.
// Depends on fded_pkg and instantiates fded_ram.
`default_nettype none

module fded_datapath #(
    parameter int NAME_BUFFER_BYTES   = fded_pkg::NAME_BUFFER_BYTES_DEF,
    parameter int MAX_LONG_NAME_ORDER = fded_pkg::MAX_LONG_NAME_ORDER_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   kind,
    input  wire logic [63:0]            entry_word0,
    input  wire logic [63:0]            entry_word1,
    input  wire logic [63:0]            entry_word2,
    input  wire logic [63:0]            entry_word3,
    input  wire fded_pkg::fded_cmd_t    cmd,
    input  wire logic                   result_stall,
    output      fded_pkg::fded_status_t status,
    output      logic                   result_valid,
    output      logic [63:0]            name_chars,
    output      logic [4:0]             chunk_index,
    output      logic                   is_directory,
    output      logic                   end_of_directory,
    output      logic                   last
);

    import fded_pkg::*;

    localparam int ROWS   = (NAME_BUFFER_BYTES + 7) / 8;
    localparam int RAM_AW = $clog2(ROWS);

    // Entry decode.
    logic [63:0]        ew [4];
    logic [7:0]         eb [32];
    logic [ORDER_W-1:0] order;
    logic [POS_W-1:0]   base_in;
    logic [POS_W-1:0]   end_pos_in;
    logic [7:0]         chars_in [LFN_CHARS];
    logic [15:0]        unit;
    logic [3:0]         nlen;
    logic [1:0]         elen;
    logic [4:0]         ext_ofs;
    logic [7:0]         sfn_in [16];

    assign ew[0] = entry_word0;
    assign ew[1] = entry_word1;
    assign ew[2] = entry_word2;
    assign ew[3] = entry_word3;

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            eb[i] = ew[i / 8][(i % 8) * 8 +: 8];
        end
    end

    assign order      = eb[0][ORDER_W-1:0];
    assign base_in    = (POS_W'(order) - POS_W'(1)) * POS_W'(LFN_CHARS);
    assign end_pos_in = base_in + POS_W'(LFN_CHARS - 1);

    always_comb
    begin
        unit = '0;
        for (int i = 0; i < LFN_CHARS; i++)
        begin
            unit = {eb[LFN_UNIT_OFS[i] + 5'd1], eb[LFN_UNIT_OFS[i]]};
            if (unit == 16'h0000 || unit == UNIT_UNUSED)
            begin
                chars_in[i] = 8'h00;
            end
            else
            begin
                chars_in[i] = {1'b0, unit[6:0]};
            end
        end
    end

    // Short 8.3 name: trailing spaces trimmed, a dot only when an extension is left.
    always_comb
    begin
        nlen    = '0;
        elen    = '0;
        ext_ofs = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (eb[k] != CHAR_SPACE)
            begin
                nlen = 4'(k + 1);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (eb[8 + k] != CHAR_SPACE)
            begin
                elen = 2'(k + 1);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            ext_ofs = 5'(i) - 5'(nlen) - 5'd1;
            if (4'(i) < nlen)
            begin
                sfn_in[i] = eb[i];
            end
            else if (elen != 2'd0 && 4'(i) == nlen)
            begin
                sfn_in[i] = CHAR_DOT;
            end
            else if (elen != 2'd0 && 4'(i) > nlen && ext_ofs < 5'(elen))
            begin
                sfn_in[i] = eb[8 + ext_ofs[1:0]];
            end
            else
            begin
                sfn_in[i] = 8'h00;
            end
        end
    end

    // Captured entry.
    logic [7:0]         chars_reg [LFN_CHARS];
    logic [POS_W-1:0]   base_reg;
    logic [ROW_W-1:0]   end_row_reg;
    logic               dir_reg;
    logic               src_long_reg;
    logic [127:0]       sfn_reg;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            for (int i = 0; i < LFN_CHARS; i++)
            begin
                chars_reg[i] <= chars_in[i];
            end
            for (int i = 0; i < 16; i++)
            begin
                sfn_reg[i * 8 +: 8] <= sfn_in[i];
            end
            base_reg     <= base_in;
            end_row_reg  <= end_pos_in[POS_W-1:3];
            dir_reg      <= eb[11][ATTR_DIR_BIT];
            src_long_reg <= cmd.src_long;
        end
    end

    always_comb
    begin
        row_next   = row_reg;
        chunk_next = chunk_reg;
        if (cmd.cap)
        begin
            row_next   = base_in[POS_W-1:3];
            chunk_next = '0;
        end
        else
        begin
            if (cmd.wr_lfn && !status.row_is_end)
            begin
                row_next = row_reg + ROW_W'(1);
            end
            if (cmd.ld_out)
            begin
                chunk_next = chunk_reg + CHUNK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            chunk_reg <= '0;
        end
        else
        begin
            row_reg   <= row_next;
            chunk_reg <= chunk_next;
        end
    end

    // Name buffer: rows of eight bytes with one valid bit per row.
    logic [ROWS-1:0]   row_valid_reg;
    logic              rvalid_reg;
    logic [ROW_W-1:0]  rd_row;
    logic              rd_en;
    logic              rd_in_range;
    logic              wr_en;
    logic [63:0]       ram_rdata;
    logic [63:0]       rdata_eff;
    logic [63:0]       wdata;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  off;
    logic              hit;

    always_comb
    begin
        if (cmd.rd_chunk)
        begin
            rd_row = ROW_W'(chunk_reg);
        end
        else if (cmd.wr_lfn)
        begin
            rd_row = row_reg + ROW_W'(1);
        end
        else
        begin
            rd_row = row_reg;
        end
    end

    assign rd_en       = cmd.rd_chunk || cmd.rd_lfn || (cmd.wr_lfn && !status.row_is_end);
    assign rd_in_range = (rd_row < ROW_W'(ROWS));
    assign wr_en       = cmd.wr_lfn && (row_reg < ROW_W'(ROWS));
    assign rdata_eff   = rvalid_reg ? ram_rdata : 64'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_buf)
            begin
                row_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                row_valid_reg[row_reg[RAM_AW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= rd_in_range && row_valid_reg[rd_row[RAM_AW-1:0]];
            end
        end
    end

    // Merge the captured characters into the row that was just read.
    always_comb
    begin
        pos   = '0;
        off   = '0;
        hit   = 1'b0;
        wdata = rdata_eff;
        for (int b = 0; b < 8; b++)
        begin
            pos = {row_reg, 3'(b)};
            off = pos - base_reg;
            hit = (pos >= base_reg) && (off < POS_W'(LFN_CHARS))
                  && (pos < POS_W'(NAME_BUFFER_BYTES - 1));
            if (hit)
            begin
                wdata[b * 8 +: 8] = chars_reg[off[3:0]];
            end
        end
    end

    fded_ram #(
        .WIDTH (64),
        .DEPTH (ROWS)
    ) u_name_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (row_reg[RAM_AW-1:0]),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_row[RAM_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Chunk formation: bytes from the first zero on read as zero.
    logic [63:0] src;
    logic [63:0] chunk_masked;
    logic        keep;
    logic        zero_seen;

    always_comb
    begin
        src          = src_long_reg ? rdata_eff : sfn_reg[chunk_reg[0] * 64 +: 64];
        chunk_masked = '0;
        keep         = 1'b1;
        for (int b = 0; b < 8; b++)
        begin
            if (src[b * 8 +: 8] == 8'h00)
            begin
                keep = 1'b0;
            end
            chunk_masked[b * 8 +: 8] = keep ? src[b * 8 +: 8] : 8'h00;
        end
        zero_seen = !keep;
    end

    // Result register.
    logic        result_valid_reg;
    logic [63:0] name_chars_reg;
    logic [4:0]  chunk_index_reg;
    logic        is_directory_reg;
    logic        end_of_directory_reg;
    logic        last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.ld_out || cmd.ld_end)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            name_chars_reg       <= chunk_masked;
            chunk_index_reg      <= chunk_reg;
            is_directory_reg     <= dir_reg;
            end_of_directory_reg <= 1'b0;
            last_reg             <= status.chunk_last;
        end
        else if (cmd.ld_end)
        begin
            name_chars_reg       <= 64'h0;
            chunk_index_reg      <= '0;
            is_directory_reg     <= 1'b0;
            end_of_directory_reg <= 1'b1;
            last_reg             <= 1'b1;
        end
    end

    assign result_valid     = result_valid_reg;
    assign name_chars       = name_chars_reg;
    assign chunk_index      = chunk_index_reg;
    assign is_directory     = is_directory_reg;
    assign end_of_directory = end_of_directory_reg;
    assign last             = last_reg;

    // Status.
    always_comb
    begin
        status.kind       = kind;
        status.first_zero = (eb[0] == 8'h00);
        status.deleted    = (eb[0] == FIRST_DELETED);
        status.lfn        = (eb[11] == ATTR_LFN);
        status.lfn_start  = eb[0][LFN_START_BIT];
        status.order_ok   = (order != '0) && (order <= ORDER_W'(MAX_LONG_NAME_ORDER));
        status.row_is_end = (row_reg == end_row_reg);
        status.chunk_last = zero_seen || (chunk_reg == LAST_CHUNK);
        status.out_free   = !result_valid_reg || !result_stall;
    end

endmodule

`default_nettype wire

// File: sim/tb_fat_directory_entry_decoder.sv
// Self-checking testbench for fat_directory_entry_decoder: directed and random
// directory listings, checked chunk by chunk against a predictor in this file.
// Depends on fded_pkg and the decoder RTL only.

module tb_fat_directory_entry_decoder;

    // Block configuration. NAME_BYTES and MAX_ORDER match the parameters of the instance below.
    localparam int NAME_BYTES = 256;
    localparam int MAX_ORDER  = 20;
    localparam int MAX_CHUNKS = 32;

    // Item kinds and entry codes.
    localparam bit          KIND_START    = 1'b0;
    localparam bit          KIND_ENTRY    = 1'b1;
    localparam logic [7:0]  FIRST_END     = 8'h00;
    localparam logic [7:0]  LFN_LAST_FLAG = 8'h40;
    localparam logic [7:0]  ORDER_MASK    = 8'h1F;
    localparam logic [7:0]  ATTR_DIR      = 8'h10;
    localparam logic [7:0]  ATTR_ARCHIVE  = 8'h20;
    localparam logic [15:0] UNIT_END      = 16'h0000;
    localparam int          LFN_UNITS     = 13;

    // Run control.
    localparam int ITEMS_TARGET = 460;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_LIMIT = 50;

    typedef struct packed {
        logic [63:0] name_chars;
        logic [4:0]  chunk_index;
        logic        is_directory;
        logic        end_of_directory;
        logic        last;
    } name_chunk_t;

    typedef logic [LFN_UNITS-1:0][15:0] lfn_units_t;

    // Every input of the block starts at a known value.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        entry_valid = 1'b0;
    logic        entry_stall;
    logic        kind = 1'b0;
    logic [63:0] entry_word0 = '0;
    logic [63:0] entry_word1 = '0;
    logic [63:0] entry_word2 = '0;
    logic [63:0] entry_word3 = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [63:0] name_chars;
    logic [4:0]  chunk_index;
    logic        is_directory;
    logic        end_of_directory;
    logic        last;

    always #1 clk = ~clk;

    fat_directory_entry_decoder #(
        .NAME_BUFFER_BYTES   (NAME_BYTES),
        .MAX_LONG_NAME_ORDER (MAX_ORDER)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .entry_valid      (entry_valid),
        .entry_stall      (entry_stall),
        .kind             (kind),
        .entry_word0      (entry_word0),
        .entry_word1      (entry_word1),
        .entry_word2      (entry_word2),
        .entry_word3      (entry_word3),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .name_chars       (name_chars),
        .chunk_index      (chunk_index),
        .is_directory     (is_directory),
        .end_of_directory (end_of_directory),
        .last             (last)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the long-name buffer and the two
    // flags that steer the decoder through a listing.
    // ------------------------------------------------------------------
    logic [7:0]  lname_buf [NAME_BYTES] = '{default: 8'h00};
    bit          lname_pending = 1'b0;
    bit          listing_closed = 1'b0;
    name_chunk_t awaited_chunks [$];

    int mismatch_count = 0;
    int items_accepted = 0;

    // Sender burst control; the receiver hold-off request counter is written
    // only by the test process and read by the receiver process.
    bit gaps_on = 1'b1;
    int burst_left = 0;
    int hold_requests = 0;

    // Byte offset of the i-th UTF-16 unit inside a long-name entry.
    function automatic int lfn_unit_offset(int i);
        if (i < 5)
        begin
            return 1 + 2 * i;
        end
        else if (i < 11)
        begin
            return 14 + 2 * (i - 5);
        end
        return 28 + 2 * (i - 11);
    endfunction

    function automatic void clear_lname_buf();
        foreach (lname_buf[i])
        begin
            lname_buf[i] = 8'h00;
        end
    endfunction

    // Applies one accepted transfer to the predictor state and queues the name
    // chunks it must produce. Returns 0 for an entry that the block ignores
    // because the listing has already ended.
    function automatic bit predict_name_chunks(bit is_entry, logic [255:0] ent);
        logic [7:0]  first;
        logic [7:0]  attr;
        logic [7:0]  name_bytes [NAME_BYTES];
        logic [15:0] unit;
        logic [63:0] word;
        name_chunk_t c;
        bit          dir;
        int          name_max;
        int          len;
        int          chunks;
        int          order;
        int          pos;
        int          nlen;
        int          elen;
        int          idx;

        if (!is_entry)
        begin
            clear_lname_buf();
            lname_pending = 1'b0;
            listing_closed = 1'b0;
            return 1'b1;
        end
        if (listing_closed)
        begin
            return 1'b0;
        end

        first = ent[7:0];
        attr  = ent[95:88];

        // A zero first byte closes the listing with a single end result.
        if (first == FIRST_END)
        begin
            c = '{name_chars: 64'd0, chunk_index: 5'd0, is_directory: 1'b0,
                  end_of_directory: 1'b1, last: 1'b1};
            awaited_chunks = {awaited_chunks, c};
            listing_closed = 1'b1;
            return 1'b1;
        end

        // A deleted entry breaks any long name that was being collected.
        if (first == fded_pkg::FIRST_DELETED)
        begin
            lname_pending = 1'b0;
            return 1'b1;
        end

        // Long-name fragment: store 13 seven-bit characters at (order-1)*13.
        if (attr == fded_pkg::ATTR_LFN)
        begin
            order = int'(first & ORDER_MASK);
            if ((first & LFN_LAST_FLAG) != 8'h00)
            begin
                clear_lname_buf();
                lname_pending = 1'b1;
            end
            if (order >= 1 && order <= MAX_ORDER)
            begin
                for (int i = 0; i < LFN_UNITS; i++)
                begin
                    unit = ent[8 * lfn_unit_offset(i) +: 16];
                    pos = (order - 1) * LFN_UNITS + i;
                    // The last byte of the buffer is never written, so a long
                    // name always ends by the end of the buffer.
                    if (pos < NAME_BYTES - 1)
                    begin
                        lname_buf[pos] = (unit == UNIT_END || unit == fded_pkg::UNIT_UNUSED) ?
                                         8'h00 : {1'b0, unit[6:0]};
                    end
                end
            end
            return 1'b1;
        end

        // Any other entry shows its name: the pending long name, else the 8.3 name.
        dir = (attr & ATTR_DIR) != 8'h00;
        foreach (name_bytes[i])
        begin
            name_bytes[i] = 8'h00;
        end
        if (lname_pending)
        begin
            lname_pending = 1'b0;
            foreach (name_bytes[i])
            begin
                name_bytes[i] = lname_buf[i];
            end
            name_max = NAME_BYTES;
        end
        else
        begin
            nlen = 8;
            while (nlen > 0 && ent[8 * (nlen - 1) +: 8] == fded_pkg::CHAR_SPACE)
            begin
                nlen--;
            end
            elen = 3;
            while (elen > 0 && ent[8 * (7 + elen) +: 8] == fded_pkg::CHAR_SPACE)
            begin
                elen--;
            end
            pos = 0;
            for (int i = 0; i < nlen; i++)
            begin
                name_bytes[pos] = ent[8 * i +: 8];
                pos++;
            end
            if (elen > 0)
            begin
                name_bytes[pos] = fded_pkg::CHAR_DOT;
                pos++;
                for (int i = 0; i < elen; i++)
                begin
                    name_bytes[pos] = ent[8 * (8 + i) +: 8];
                    pos++;
                end
            end
            name_max = 13;
        end

        // The name runs up to its first zero byte; the chunk that holds that
        // zero is the last one.
        len = 0;
        while (len < name_max && name_bytes[len] != 8'h00)
        begin
            len++;
        end
        chunks = len / 8 + 1;
        if (chunks > MAX_CHUNKS)
        begin
            chunks = MAX_CHUNKS;
        end
        for (int n = 0; n < chunks; n++)
        begin
            word = '0;
            for (int b = 0; b < 8; b++)
            begin
                idx = n * 8 + b;
                if (idx < len)
                begin
                    word[8 * b +: 8] = name_bytes[idx];
                end
            end
            c.name_chars       = word;
            c.chunk_index      = 5'(n);
            c.is_directory     = dir;
            c.end_of_directory = 1'b0;
            c.last             = (n == chunks - 1);
            awaited_chunks = {awaited_chunks, c};
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [255:0] rand256();
        return {rand64(), rand64(), rand64(), rand64()};
    endfunction

    // Short entry with a space-padded 8.3 name; the tail bytes are random.
    function automatic logic [255:0] named_entry(string nm, string ex, logic [7:0] attr);
        logic [255:0] e;

        e = rand256();
        for (int i = 0; i < 8; i++)
        begin
            e[8 * i +: 8] = (i < nm.len()) ? nm[i] : fded_pkg::CHAR_SPACE;
        end
        for (int i = 0; i < 3; i++)
        begin
            e[8 * (8 + i) +: 8] = (i < ex.len()) ? ex[i] : fded_pkg::CHAR_SPACE;
        end
        e[95:88] = attr;
        return e;
    endfunction

    function automatic logic [255:0] deleted_entry();
        logic [255:0] e;

        e = rand256();
        e[7:0] = fded_pkg::FIRST_DELETED;
        return e;
    endfunction

    function automatic logic [255:0] end_entry();
        logic [255:0] e;

        e = rand256();
        e[7:0] = FIRST_END;
        return e;
    endfunction

    function automatic logic [255:0] lfn_entry(logic [7:0] first, lfn_units_t units);
        logic [255:0] e;

        e = rand256();
        e[7:0] = first;
        e[95:88] = fded_pkg::ATTR_LFN;
        for (int u = 0; u < LFN_UNITS; u++)
        begin
            e[8 * lfn_unit_offset(u) +: 16] = units[u];
        end
        return e;
    endfunction

    // The units of one fragment of a text name, terminated and padded as a
    // real file system writes them.
    function automatic lfn_units_t lfn_units_from_text(string s, int frag);
        lfn_units_t units;
        int         p;

        for (int u = 0; u < LFN_UNITS; u++)
        begin
            p = (frag - 1) * LFN_UNITS + u;
            if (p < s.len())
            begin
                units[u] = {8'h00, s[p]};
            end
            else if (p == s.len())
            begin
                units[u] = UNIT_END;
            end
            else
            begin
                units[u] = fded_pkg::UNIT_UNUSED;
            end
        end
        return units;
    endfunction

    // Mostly printable characters; now and then a unit with a high byte, so
    // that only its low seven bits survive.
    function automatic logic [15:0] rand_name_unit();
        logic [7:0] hi;
        logic [7:0] lo;

        if ($urandom_range(0, 19) == 0)
        begin
            hi = 8'($urandom_range(1, 255));
            lo = 8'($urandom_range(0, 255));
        end
        else
        begin
            hi = 8'h00;
            lo = 8'($urandom_range(8'h21, 8'h7E));
        end
        return {hi, lo};
    endfunction

    function automatic logic [255:0] random_short_entry();
        logic [63:0]  nm;
        logic [23:0]  ex;
        logic [7:0]   attr;
        logic [255:0] e;
        int           nl;
        int           el;
        int           r;

        nm = {8{fded_pkg::CHAR_SPACE}};
        ex = {3{fded_pkg::CHAR_SPACE}};
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            nm = rand64();
            ex = 24'($urandom);
        end
        else
        begin
            nl = $urandom_range(0, 8);
            el = $urandom_range(0, 3);
            for (int i = 0; i < nl; i++)
            begin
                nm[8 * i +: 8] = 8'($urandom_range(8'h20, 8'h7E));
            end
            for (int i = 0; i < el; i++)
            begin
                ex[8 * i +: 8] = 8'($urandom_range(8'h20, 8'h7E));
            end
            // A zero byte inside the raw name cuts the name short.
            if (r == 1)
            begin
                nm[8 * $urandom_range(1, 7) +: 8] = 8'h00;
            end
        end
        // Keep it a plain entry: not the end marker, not a deleted slot.
        if (nm[7:0] == FIRST_END || nm[7:0] == fded_pkg::FIRST_DELETED)
        begin
            nm[7:0] = 8'h41;
        end
        attr = 8'($urandom_range(0, 255));
        if (attr == fded_pkg::ATTR_LFN)
        begin
            attr = ATTR_DIR;
        end
        e = rand256();
        e[63:0] = nm;
        e[87:64] = ex;
        e[95:88] = attr;
        return e;
    endfunction

    // Offers one item and holds it until the block takes it. In burst mode the
    // valid line drops for a random gap between bursts; within a burst it stays
    // high from one item to the next.
    task automatic send_item(input bit item_kind, input logic [255:0] ent);
        int gap;

        if (gaps_on && burst_left <= 0)
        begin
            entry_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        entry_valid <= 1'b1;
        kind        <= item_kind;
        entry_word0 <= ent[63:0];
        entry_word1 <= ent[127:64];
        entry_word2 <= ent[191:128];
        entry_word3 <= ent[255:192];
        @(posedge clk);
        while (entry_stall)
        begin
            @(posedge clk);
        end
        if (predict_name_chunks(item_kind, ent))
        begin
            items_accepted++;
        end
    endtask

    // Sends the fragments of a long name from the highest order down, then
    // the short entry they belong to. A flaw breaks the sequence: 1 leaves off
    // the start flag, 2 drops a lower fragment, 3 puts a deleted slot before
    // the short entry.
    task automatic send_long_name(input int frags, input int char_total, input int flaw);
        lfn_units_t units;
        logic [7:0] first;
        int         skip;
        int         p;

        skip = (flaw == 2 && frags > 1) ? $urandom_range(1, frags - 1) : 0;
        for (int f = frags; f >= 1; f--)
        begin
            if (f == skip)
            begin
                continue;
            end
            for (int u = 0; u < LFN_UNITS; u++)
            begin
                p = (f - 1) * LFN_UNITS + u;
                if (p < char_total)
                begin
                    units[u] = rand_name_unit();
                end
                else if (p == char_total)
                begin
                    units[u] = UNIT_END;
                end
                else
                begin
                    units[u] = fded_pkg::UNIT_UNUSED;
                end
            end
            first = 8'(f);
            if (f == frags && flaw != 1)
            begin
                first = first | LFN_LAST_FLAG;
            end
            send_item(KIND_ENTRY, lfn_entry(first, units));
        end
        if (flaw == 3)
        begin
            send_item(KIND_ENTRY, deleted_entry());
        end
        send_item(KIND_ENTRY, random_short_entry());
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // 8.3 names: trimming, the dot, empty names, names of exactly eight
    // characters and zero bytes inside the raw name.
    task automatic test_short_names();
        logic [255:0] e;

        send_item(KIND_ENTRY, named_entry("README", "TXT", ATTR_ARCHIVE));
        send_item(KIND_ENTRY, named_entry("ABCDEFGH", "XYZ", ATTR_DIR));
        send_item(KIND_ENTRY, named_entry("ABCDEFGH", "", ATTR_ARCHIVE));
        send_item(KIND_ENTRY, named_entry("", "", 8'hFF));
        send_item(KIND_ENTRY, named_entry("A B", "T", 8'h00));
        send_item(KIND_ENTRY, named_entry("NOEXT", "", ATTR_DIR));
        e = named_entry("ABXCDEFG", "EXT", ATTR_ARCHIVE);
        e[23:16] = 8'h00;
        send_item(KIND_ENTRY, e);
    endtask

    // Long-name assembly: two fragments with terminator and padding, a unit
    // with a high byte, a deleted slot that drops the name, a fragment with no
    // start flag, and start flags on orders of zero and above the limit.
    task automatic test_long_names();
        lfn_units_t units;
        string      full_name;

        full_name = "Long-File-Name.txt";
        units = lfn_units_from_text(full_name, 2);
        send_item(KIND_ENTRY, lfn_entry(LFN_LAST_FLAG | 8'd2, units));
        units = lfn_units_from_text(full_name, 1);
        units[3] = 16'hA345;
        send_item(KIND_ENTRY, lfn_entry(8'd1, units));
        send_item(KIND_ENTRY, named_entry("LONG-F~1", "TXT", ATTR_ARCHIVE));

        send_item(KIND_ENTRY, lfn_entry(LFN_LAST_FLAG | 8'd1, lfn_units_from_text("gone", 1)));
        send_item(KIND_ENTRY, deleted_entry());
        send_item(KIND_ENTRY, named_entry("KEEP", "DAT", ATTR_DIR));

        send_item(KIND_ENTRY, lfn_entry(8'd1, lfn_units_from_text("xyz", 1)));
        send_item(KIND_ENTRY, named_entry("SHORT", "C", ATTR_ARCHIVE));

        send_item(KIND_ENTRY, lfn_entry(LFN_LAST_FLAG, lfn_units_from_text("zero", 1)));
        send_item(KIND_ENTRY, named_entry("EMPTY1", "", ATTR_DIR));

        send_item(KIND_ENTRY, lfn_entry(LFN_LAST_FLAG | 8'(MAX_ORDER + 1),
                                        lfn_units_from_text("over", 1)));
        send_item(KIND_ENTRY, named_entry("EMPTY2", "", ATTR_ARCHIVE));
    endtask

    // The end marker closes the listing; later entries are ignored until the
    // next start marker.
    task automatic test_end_of_listing();
        send_item(KIND_START, rand256());
        send_item(KIND_ENTRY, end_entry());
        send_item(KIND_ENTRY, named_entry("IGNORED", "", ATTR_ARCHIVE));
        send_item(KIND_ENTRY, lfn_entry(LFN_LAST_FLAG | 8'd1, lfn_units_from_text("x", 1)));
        send_item(KIND_START, rand256());
        send_item(KIND_ENTRY, named_entry("AFTER", "", ATTR_DIR));
    endtask

    // The receiver holds off for a long stretch while full-length names keep
    // coming, so the result side backs up into the entry side.
    task automatic test_output_backpressure();
        hold_requests <= hold_requests + 1;
        gaps_on = 1'b0;
        send_long_name(MAX_ORDER, NAME_BYTES - 1, 0);
        for (int i = 0; i < 6; i++)
        begin
            send_item(KIND_ENTRY, random_short_entry());
        end
        send_long_name(MAX_ORDER, NAME_BYTES - 1, 0);
        gaps_on = 1'b1;
    endtask

    // Random listings: mostly well-formed long names with random content and
    // plain entries, with deleted slots, ends of listing, noise and broken
    // sequences mixed in.
    task automatic test_random_listings();
        logic [255:0] e;
        int           pick;
        int           frags;
        int           nlen;
        int           flaw;
        int           extra;

        while (items_accepted < ITEMS_TARGET)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                gaps_on = !gaps_on;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_item(KIND_START, rand256());
            end
            else if (pick < 50)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    frags = $urandom_range(1, 3);
                end
                else if (pick < 95)
                begin
                    frags = $urandom_range(4, 8);
                end
                else
                begin
                    frags = $urandom_range(9, MAX_ORDER);
                end
                nlen = $urandom_range((frags - 1) * LFN_UNITS + 1, frags * LFN_UNITS);
                if (nlen > NAME_BYTES - 1)
                begin
                    nlen = NAME_BYTES - 1;
                end
                flaw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
                send_long_name(frags, nlen, flaw);
            end
            else if (pick < 80)
            begin
                send_item(KIND_ENTRY, random_short_entry());
            end
            else if (pick < 87)
            begin
                send_item(KIND_ENTRY, deleted_entry());
            end
            else if (pick < 92)
            begin
                send_item(1'($urandom_range(0, 1)), rand256());
            end
            else if (pick < 96)
            begin
                e = rand256();
                e[95:88] = fded_pkg::ATTR_LFN;
                send_item(KIND_ENTRY, e);
            end
            else
            begin
                send_item(KIND_ENTRY, end_entry());
                extra = $urandom_range(0, 3);
                repeat (extra) send_item(KIND_ENTRY, rand256());
                if ($urandom_range(0, 9) != 0)
                begin
                    send_item(KIND_START, rand256());
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < REPORT_LIMIT)
        begin
            $display("mismatch: %s got %h expected %h", what, got, want);
        end
        mismatch_count++;
    endtask

    // Every result transfer is compared with the oldest awaited chunk.
    always @(posedge clk)
    begin : check_results
        name_chunk_t want;

        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_chunks.size() == 0)
            begin
                report_mismatch("result with none awaited, name_chars", name_chars, 64'd0);
            end
            else
            begin
                want = awaited_chunks.pop_front();
                if (name_chars !== want.name_chars)
                begin
                    report_mismatch("name_chars", name_chars, want.name_chars);
                end
                if (chunk_index !== want.chunk_index)
                begin
                    report_mismatch("chunk_index", 64'(chunk_index), 64'(want.chunk_index));
                end
                if (is_directory !== want.is_directory)
                begin
                    report_mismatch("is_directory", 64'(is_directory), 64'(want.is_directory));
                end
                if (end_of_directory !== want.end_of_directory)
                begin
                    report_mismatch("end_of_directory", 64'(end_of_directory),
                                    64'(want.end_of_directory));
                end
                if (last !== want.last)
                begin
                    report_mismatch("last", 64'(last), 64'(want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls on a pattern that changes mode every so often (none,
    // light random, heavy random, periodic). A hold-off request from a test
    // overrides the pattern with an unbroken stall.
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left = 0;
    int stall_phase = 0;
    int hold_left = 0;
    int hold_served = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD - 1;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 160);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= ((stall_phase % 5) < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when the idle counter, which any transfer on either
    // side clears, reaches IDLE_LIMIT.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((entry_valid && !entry_stall) || (result_valid && !result_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d chunks still awaited",
                     IDLE_LIMIT, awaited_chunks.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_short_names();
        test_long_names();
        test_end_of_listing();
        test_output_backpressure();
        test_random_listings();
        entry_valid <= 1'b0;

        // Drain: wait for every awaited chunk, then give the block time to
        // show any stray result.
        while (awaited_chunks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
